/* rtl/sslw_pkg.sv */
// Shared types and constants for the snapshot sequence filter and link watchdog.
// Used by the channel interfaces, the per-transport slot and the top level.
package sslw_pkg;

  localparam int unsigned TR_W   = 2;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam int unsigned SERIAL_INDEX = 0;

  typedef enum logic [1:0] {
    MODE_SNAP   = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_ACTIVE = 2'd2,
    MODE_ADOPT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_LOST = 2'd1,
    EDGE_BACK = 2'd2,
    EDGE_RSVD = 2'd3
  } link_edge_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LINK_TIMEOUT = 1'b0,
    CFG_RESYNC_WINDOW = 1'b1
  } cfg_addr_t;

  localparam logic [CFG_W-1:0] LINK_TIMEOUT_RST = 31'd15000;
  localparam logic [CFG_W-1:0] RESYNC_WINDOW_RST = 31'd30000;

  // Per-transport control from the decision logic to one slot.
  typedef struct packed {
    logic             apply;      // snapshot applied: store seq, mark valid, clear adopt
    logic             set_adopt;  // force adoption of the next snapshot
    logic [SEQ_W-1:0] seq;
  } slot_ctrl_t;

  // Per-transport status back to the decision logic.
  typedef struct packed {
    logic             adopt;
    logic             seq_valid;
    logic [SEQ_W-1:0] last_seq;
  } slot_stat_t;

endpackage

/* rtl/sslw_if.sv */
// Channel interfaces: event input, result output and configuration write.
// Depends on sslw_pkg for field widths.
interface sslw_evt_if;
  import sslw_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [TR_W-1:0]     transport;
  logic [SEQ_W-1:0]    seq;
  logic [TIME_W-1:0]   now_ms;
  modport src (output valid, mode, transport, seq, now_ms, input ready);
  modport snk (input valid, mode, transport, seq, now_ms, output ready);
endinterface

interface sslw_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       resynced;
  logic [1:0] link_edge;
  modport src (output valid, accepted, resynced, link_edge, input ready);
  modport snk (input valid, accepted, resynced, link_edge, output ready);
endinterface

interface sslw_cfg_if;
  import sslw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_W-1:0]      data;
  modport src (output valid, addr, data, input ready);
  modport snk (input valid, addr, data, output ready);
endinterface

/* rtl/sslw_slot.sv */
// Sequence state of one transport: last sequence, have-sequence and adopt-next flags.
// Depends on sslw_pkg for the slot control and status structs.
module sslw_slot (
  input  logic                clk,
  input  logic                rst,
  input  sslw_pkg::slot_ctrl_t ctrl,
  output sslw_pkg::slot_stat_t stat
);
  import sslw_pkg::*;

  logic             adopt;
  logic             seq_valid;
  logic [SEQ_W-1:0] last_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      adopt     <= 1'b0;
      seq_valid <= 1'b0;
    end else if (ctrl.apply) begin
      adopt     <= 1'b0;
      seq_valid <= 1'b1;
    end else if (ctrl.set_adopt) begin
      adopt <= 1'b1;
    end
  end

  // last_seq is only looked at once seq_valid is set
  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      last_seq <= ctrl.seq;
    end
  end

  assign stat.adopt     = adopt;
  assign stat.seq_valid = seq_valid;
  assign stat.last_seq  = last_seq;

endmodule

/* rtl/snapshot_sequence_filter_link_watchdog_core.sv */
// Snapshot sequence filter and link watchdog, top level.
// Each item taken is held in the input register, then its result is registered.
// Throughput: one item per cycle unless the result channel stalls; the input
// and result registers move together, so the next item sees what one item wrote.
// Reset (synchronous, rst high): configuration back to defaults, all transports
// without sequence, serial transport active, link not lost, channels empty.
module snapshot_sequence_filter_link_watchdog_core #(
  parameter int unsigned TRANSPORTS = 2
) (
  input logic       clk,
  input logic       rst,
  sslw_evt_if.snk   evt,
  sslw_res_if.src   res,
  sslw_cfg_if.snk   cfg
);
  import sslw_pkg::*;

  localparam logic [TR_W:0] TR_CNT = (TR_W+1)'(TRANSPORTS);

  // configuration
  logic [CFG_W-1:0] link_timeout;
  logic [CFG_W-1:0] resync_window;

  // input register
  logic              s1_valid;
  logic [1:0]        s1_mode;
  logic [TR_W-1:0]   s1_tr;
  logic [SEQ_W-1:0]  s1_seq;
  logic [TIME_W-1:0] s1_now;

  // block state
  logic [TIME_W-1:0] last_time;
  logic [TR_W-1:0]   active;
  logic              lost_flag;

  // result register
  logic       out_valid;
  logic       out_acc;
  logic       out_rs;
  logic [1:0] out_edge;

  slot_ctrl_t slot_ctrl [TRANSPORTS];
  slot_stat_t slot_stat [TRANSPORTS];

  logic              s1_fire;
  logic              in_range;
  logic              is_active;
  slot_stat_t        sel;
  logic [SEQ_W-1:0]  seq_diff;
  logic              newer;
  logic [TIME_W-1:0] age;
  logic              resync_ok;
  logic              lost;
  logic              snap;
  logic              acc;
  logic              rs;
  logic [1:0]        edge_code;
  logic              lost_next;
  logic              set_active;

  assign s1_fire   = s1_valid && (!out_valid || res.ready);
  assign evt.ready = !s1_valid || s1_fire;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout  <= LINK_TIMEOUT_RST;
      resync_window <= RESYNC_WINDOW_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_LINK_TIMEOUT:  link_timeout  <= cfg.data;
        CFG_RESYNC_WINDOW: resync_window <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_mode <= evt.mode;
      s1_tr   <= evt.transport;
      s1_seq  <= evt.seq;
      s1_now  <= evt.now_ms;
    end
  end

  // pick the addressed transport's status
  always_comb begin
    sel = '0;
    for (int unsigned i = 0; i < TRANSPORTS; i++) begin
      if (s1_tr == TR_W'(i)) begin
        sel = slot_stat[i];
      end
    end
  end

  assign in_range  = {1'b0, s1_tr} < TR_CNT;
  assign is_active = s1_tr == active;
  assign seq_diff  = s1_seq - sel.last_seq;
  assign newer     = (seq_diff != '0) && !seq_diff[SEQ_W-1];
  // a negative (future) age neither times out nor opens the resync window
  assign age       = s1_now - last_time;
  assign resync_ok = !age[TIME_W-1] && (age[CFG_W-1:0] >= resync_window);
  assign lost      = !age[TIME_W-1] && (age[CFG_W-1:0] > link_timeout);

  always_comb begin
    snap       = 1'b0;
    acc        = 1'b0;
    rs         = 1'b0;
    edge_code  = EDGE_NONE;
    lost_next  = lost_flag;
    set_active = 1'b0;
    unique case (s1_mode)
      MODE_SNAP: begin
        snap = in_range && is_active;
        priority if (sel.adopt) begin
          acc = snap;
        end else if (sel.seq_valid && !newer) begin
          rs  = snap && (s1_tr == TR_W'(SERIAL_INDEX)) && resync_ok;
          acc = rs;
        end else begin
          acc = snap;
        end
      end
      MODE_POLL: begin
        lost_next = lost;
        if (lost && !lost_flag) begin
          edge_code = EDGE_LOST;
        end else if (!lost && lost_flag) begin
          edge_code = EDGE_BACK;
        end
      end
      MODE_ACTIVE: begin
        set_active = in_range && !is_active;
      end
      MODE_ADOPT: ;
      default: ;
    endcase
  end

  for (genvar g = 0; g < TRANSPORTS; g++) begin : g_slot
    logic hit;
    assign hit = in_range && (s1_tr == TR_W'(g));
    assign slot_ctrl[g].apply     = s1_fire && hit && acc;
    assign slot_ctrl[g].set_adopt = s1_fire && hit &&
                                    ((s1_mode == MODE_ADOPT) ||
                                     ((s1_mode == MODE_ACTIVE) && !is_active));
    assign slot_ctrl[g].seq       = s1_seq;

    sslw_slot u_slot (
      .clk  (clk),
      .rst  (rst),
      .ctrl (slot_ctrl[g]),
      .stat (slot_stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      active    <= TR_W'(SERIAL_INDEX);
      lost_flag <= 1'b0;
    end else if (s1_fire) begin
      if (acc) begin
        last_time <= s1_now;
      end
      if (set_active) begin
        active <= s1_tr;
      end
      lost_flag <= lost_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_acc  <= acc;
      out_rs   <= rs;
      out_edge <= edge_code;
    end
  end

  assign res.valid     = out_valid;
  assign res.accepted  = out_acc;
  assign res.resynced  = out_rs;
  assign res.link_edge = out_edge;

  a_rs_implies_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rs |-> out_acc)
    else $error("resync reported without acceptance");

  a_acc_no_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_acc |-> out_edge == EDGE_NONE)
    else $error("acceptance and link edge in one result");

  a_time_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire && acc |=> last_time == $past(s1_now))
    else $error("applied time not captured");

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, active} < TR_CNT)
    else $error("active transport out of range");

endmodule

/* tb/sv/tb_snapshot_sequence_filter_link_watchdog_core.sv */
// Testbench for the snapshot sequence filter and link watchdog core: queued stimulus
// driven with random gaps and backpressure, results checked against an in-bench predictor.
// Depends on sslw_pkg, the sslw channel interfaces and the core RTL.
module tb_snapshot_sequence_filter_link_watchdog_core;
  import sslw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TRANSPORTS = 2;
  localparam int unsigned CHUNK_ITEMS = 205;

  typedef struct {
    mode_t             mode;
    logic [TR_W-1:0]   transport;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] now_ms;
  } snap_evt_t;

  typedef struct {
    logic       accepted;
    logic       resynced;
    link_edge_t link_edge;
  } link_res_t;

  logic clk;
  logic rst;

  sslw_evt_if evt_ch();
  sslw_res_if res_ch();
  sslw_cfg_if cfg_ch();

  snapshot_sequence_filter_link_watchdog_core #(
    .TRANSPORTS(TRANSPORTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  snap_evt_t   pending_events[$];
  link_res_t   expected_results[$];
  snap_evt_t   offered;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors;
  logic        hold_req;
  logic        rx_hold;

  // Predicted state of the block
  logic [CFG_W-1:0]  link_timeout;
  logic [CFG_W-1:0]  resync_window;
  logic [TIME_W-1:0] last_applied;
  logic [TR_W-1:0]   active_tr;
  logic [SEQ_W-1:0]  last_seq[4];
  logic              seq_known[4];
  logic              adopt_next[4];
  logic              link_lost;

  // Stimulus generator state
  logic [TIME_W-1:0] gen_time;
  logic [SEQ_W-1:0]  gen_seq[4];
  logic [TR_W-1:0]   gen_active;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic link_res_t filter_and_watch(snap_evt_t e);
    link_res_t               r;
    logic                    in_range;
    logic                    lost_now;
    logic signed [TIME_W-1:0] age;
    logic [SEQ_W-1:0]        seq_gap;
    r.accepted  = 1'b0;
    r.resynced  = 1'b0;
    r.link_edge = EDGE_NONE;
    in_range = e.transport < TRANSPORTS;
    age = e.now_ms - last_applied;
    seq_gap = e.seq - last_seq[e.transport];
    case (e.mode)
      MODE_SNAP: begin
        if (in_range && e.transport == active_tr) begin
          if (adopt_next[e.transport]) begin
            adopt_next[e.transport] = 1'b0;
            r.accepted = 1'b1;
          end else if (seq_known[e.transport] && !(seq_gap != 0 && seq_gap < 16'h8000)) begin
            // stale: only the serial link may resync after the window
            if (e.transport == SERIAL_INDEX && age >= $signed({1'b0, resync_window})) begin
              r.accepted = 1'b1;
              r.resynced = 1'b1;
            end
          end else begin
            r.accepted = 1'b1;
          end
          if (r.accepted) begin
            last_seq[e.transport]  = e.seq;
            seq_known[e.transport] = 1'b1;
            last_applied = e.now_ms;
          end
        end
      end
      MODE_POLL: begin
        lost_now = age > $signed({1'b0, link_timeout});
        if (lost_now && !link_lost) begin
          link_lost = 1'b1;
          r.link_edge = EDGE_LOST;
        end else if (!lost_now && link_lost) begin
          link_lost = 1'b0;
          r.link_edge = EDGE_BACK;
        end
      end
      MODE_ACTIVE: begin
        if (in_range && e.transport != active_tr) begin
          active_tr = e.transport;
          adopt_next[e.transport] = 1'b1;
        end
      end
      default: begin
        if (in_range) adopt_next[e.transport] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Event driver: hold an offered item until taken, then pick the next one
  always @(posedge clk) begin : event_driver
    logic busy;
    if (rst) begin
      evt_ch.valid <= 1'b0;
    end else begin
      busy = evt_ch.valid;
      if (evt_ch.valid && evt_ch.ready) begin
        expected_results.push_back(filter_and_watch(offered));
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_events.pop_front();
          evt_ch.valid     <= 1'b1;
          evt_ch.mode      <= offered.mode;
          evt_ch.transport <= offered.transport;
          evt_ch.seq       <= offered.seq;
          evt_ch.now_ms    <= offered.now_ms;
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    link_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, res_ch.accepted);
          errors++;
        end
        if (res_ch.resynced !== want.resynced) begin
          $error("resynced: expected %0d, got %0d", want.resynced, res_ch.resynced);
          errors++;
        end
        if (res_ch.link_edge !== want.link_edge) begin
          $error("link_edge: expected %0d, got %0d", want.link_edge, res_ch.link_edge);
          errors++;
        end
      end
    end
    res_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall, counted here once requested
  initial begin : rx_backpressure
    rx_hold = 1'b0;
    wait (hold_req);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (300) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin : watchdog_limit
    #2_000_000;
    $display("tb_snapshot_sequence_filter_link_watchdog_core: errors");
    $finish;
  end

  task automatic push_evt(mode_t m, logic [TR_W-1:0] tr, logic [SEQ_W-1:0] s,
                          logic [TIME_W-1:0] t);
    snap_evt_t e;
    e.mode = m;
    e.transport = tr;
    e.seq = s;
    e.now_ms = t;
    pending_events.push_back(e);
  endtask

  task automatic write_reg(cfg_addr_t a, logic [CFG_W-1:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= a;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (a == CFG_LINK_TIMEOUT) link_timeout = d;
    else resync_window = d;
  endtask

  // Sender pause: wait until every item is taken and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() > 0 || evt_ch.valid || expected_results.size() > 0);
    repeat (3) @(negedge clk);
  endtask

  // Mostly well-formed traffic: time moving forward, sequences counting up on
  // the active link, with stale, half-range, foreign and out-of-range items mixed in.
  task automatic push_random(int unsigned n, int unsigned step_max);
    int unsigned pick;
    int unsigned r;
    mode_t m;
    logic [TR_W-1:0] tr;
    logic [SEQ_W-1:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) gen_time = $urandom;
      else gen_time += $urandom_range(step_max, 0);
      pick = $urandom_range(99);
      m = pick < 55 ? MODE_SNAP : pick < 78 ? MODE_POLL : pick < 89 ? MODE_ACTIVE : MODE_ADOPT;
      r = $urandom_range(99);
      if (r < 8) tr = TR_W'($urandom_range(3, 2));
      else if (r < 22) tr = gen_active ^ 2'd1;
      else tr = gen_active;
      r = $urandom_range(99);
      if (r < 70) begin
        gen_seq[tr] += SEQ_W'($urandom_range(4, 1));
        s = gen_seq[tr];
      end else if (r < 80) begin
        s = gen_seq[tr] - SEQ_W'($urandom_range(3, 0));
      end else if (r < 87) begin
        s = gen_seq[tr] + 16'h8000;
      end else if (r < 93) begin
        s = gen_seq[tr] + SEQ_W'($urandom_range(16'h7FFF, 16'h7FF0));
      end else begin
        s = SEQ_W'($urandom);
      end
      if (m == MODE_ACTIVE && tr < TRANSPORTS) gen_active = tr;
      push_evt(m, tr, s, gen_time);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] t_cfg;
    logic [CFG_W-1:0] w_cfg;
    int unsigned      step_max;
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    hold_req = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 48;
    evt_ch.valid = 1'b0;
    evt_ch.mode = MODE_POLL;
    evt_ch.transport = '0;
    evt_ch.seq = '0;
    evt_ch.now_ms = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = CFG_LINK_TIMEOUT;
    cfg_ch.data = '0;
    link_timeout = LINK_TIMEOUT_RST;
    resync_window = RESYNC_WINDOW_RST;
    last_applied = '0;
    active_tr = SERIAL_INDEX;
    link_lost = 1'b0;
    for (int i = 0; i < 4; i++) begin
      last_seq[i] = '0;
      seq_known[i] = 1'b0;
      adopt_next[i] = 1'b0;
      gen_seq[i] = '0;
    end
    gen_time = '0;
    gen_active = SERIAL_INDEX;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: first sequence, stale and half-range sequences, foreign and
    // out-of-range transports, lost and came-back edges around the timeout,
    // future timestamps, serial resync at the window, forced adoption.
    push_evt(MODE_POLL,   0, 16'h0000, 32'd0);
    push_evt(MODE_SNAP,   0, 16'hFFFF, 32'd100);
    push_evt(MODE_SNAP,   0, 16'hFFFF, 32'd200);
    push_evt(MODE_SNAP,   0, 16'h7FFE, 32'd300);
    push_evt(MODE_SNAP,   0, 16'hFFFE, 32'd400);
    push_evt(MODE_SNAP,   1, 16'h0005, 32'd500);
    push_evt(MODE_SNAP,   3, 16'h0001, 32'd600);
    push_evt(MODE_ACTIVE, 3, 16'h0000, 32'd700);
    push_evt(MODE_ADOPT,  2, 16'h0000, 32'd800);
    push_evt(MODE_POLL,   0, 16'h0000, 32'd15301);
    push_evt(MODE_POLL,   0, 16'h0000, 32'd15302);
    push_evt(MODE_POLL,   0, 16'h0000, 32'd15300);
    push_evt(MODE_POLL,   0, 16'h0000, 32'hFFFF_FFFF);
    push_evt(MODE_POLL,   0, 16'h0000, 32'h8000_012B);
    push_evt(MODE_POLL,   0, 16'h0000, 32'h8000_012C);
    push_evt(MODE_SNAP,   0, 16'h7FFE, 32'd30300);
    push_evt(MODE_SNAP,   0, 16'h7FFE, 32'd60299);
    push_evt(MODE_ADOPT,  0, 16'h0000, 32'd60300);
    push_evt(MODE_SNAP,   0, 16'h0001, 32'd60400);
    push_evt(MODE_ACTIVE, 0, 16'h0000, 32'd60500);
    push_evt(MODE_SNAP,   0, 16'h0001, 32'd60600);
    push_evt(MODE_ACTIVE, 1, 16'h0000, 32'd60700);
    push_evt(MODE_SNAP,   1, 16'h0000, 32'd60800);
    push_evt(MODE_SNAP,   1, 16'h0000, 32'h7FFF_0000);
    push_evt(MODE_SNAP,   0, 16'hFFFF, 32'h7FFF_0100);
    push_evt(MODE_ACTIVE, 0, 16'h0000, 32'h7FFF_0200);
    push_evt(MODE_SNAP,   0, 16'h0000, 32'hFFFF_FFFF);
    wait_drained();
    gen_time = 32'hFFFF_FFFF;

    for (int c = 0; c < 6; c++) begin
      send_idle_pct = c < 2 ? 34 : c < 4 ? 48 : 0;
      recv_idle_pct = c < 2 ? 48 : c < 4 ? 34 : 0;
      case (c)
        0: begin t_cfg = 31'd1000; w_cfg = 31'd3000; end
        1: begin t_cfg = '0; w_cfg = '0; gen_time = 32'hFFFF_FF80; end
        2: begin t_cfg = '1; w_cfg = '1; end
        3: begin
          t_cfg = CFG_W'($urandom_range(500, 50));
          w_cfg = CFG_W'($urandom_range(2000, 100));
        end
        4: begin t_cfg = 31'd200; w_cfg = 31'd100; end
        default: begin t_cfg = CFG_W'($urandom); w_cfg = CFG_W'($urandom); end
      endcase
      write_reg(CFG_LINK_TIMEOUT, t_cfg);
      write_reg(CFG_RESYNC_WINDOW, w_cfg);
      step_max = ((t_cfg > w_cfg ? t_cfg : w_cfg) >> 2) + 8;
      if (step_max > 32'h4000_0000) step_max = 32'h4000_0000;
      @(negedge clk);
      if (c == 3) begin
        push_random(CHUNK_ITEMS / 2, step_max);
        wait_drained();
        push_random(CHUNK_ITEMS - CHUNK_ITEMS / 2, step_max);
      end else begin
        push_random(CHUNK_ITEMS, step_max);
      end
      if (c == 0) hold_req = 1'b1;
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_snapshot_sequence_filter_link_watchdog_core: clean");
    end else begin
      $display("tb_snapshot_sequence_filter_link_watchdog_core: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sslw_pkg.sv
rtl/sslw_if.sv
rtl/sslw_slot.sv
rtl/snapshot_sequence_filter_link_watchdog_core.sv
tb/sv/tb_snapshot_sequence_filter_link_watchdog_core.sv
